// ===== rtl/slps_pkg.sv =====
// shared types, codes and reset constants for the status led pattern sequencer
package slps_pkg;

    localparam int unsigned PERIOD_W = 16;
    localparam int unsigned COUNT_W  = 4;
    localparam int unsigned MODE_W   = 3;
    localparam int unsigned LED_W    = 3;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 16;

    typedef enum logic [MODE_W-1:0] {
        MODE_CONNECTING  = 3'd0,
        MODE_OFFLINE     = 3'd1,
        MODE_CONNECTED   = 3'd2,
        MODE_LOCK        = 3'd3,
        MODE_UNLOCK_OK   = 3'd4,
        MODE_UNLOCK_FAIL = 3'd5
    } mode_t;

    // input beat kinds
    localparam logic ACT_TICK     = 1'b0;
    localparam logic ACT_SET_MODE = 1'b1;

    // led bit patterns: bit0 red, bit1 green, bit2 blue
    localparam logic [LED_W-1:0] LED_OFF = 3'b000;
    localparam logic [LED_W-1:0] LED_R   = 3'b001;
    localparam logic [LED_W-1:0] LED_G   = 3'b010;
    localparam logic [LED_W-1:0] LED_B   = 3'b100;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BLINK_PERIOD  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FLASH_PERIOD  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LOCK_HOLD     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FLASH_TOGGLES = 2'd3;

    localparam logic [PERIOD_W-1:0] BLINK_PERIOD_RST  = 16'd300;
    localparam logic [PERIOD_W-1:0] FLASH_PERIOD_RST  = 16'd200;
    localparam logic [PERIOD_W-1:0] LOCK_HOLD_RST     = 16'd1000;
    localparam logic [COUNT_W-1:0]  FLASH_TOGGLES_RST = 4'd6;

    typedef struct packed {
        logic [PERIOD_W-1:0] blink_period;
        logic [PERIOD_W-1:0] flash_period;
        logic [PERIOD_W-1:0] lock_hold;
        logic [COUNT_W-1:0]  flash_toggles;
    } cfg_t;

endpackage

// ===== rtl/slps_cfg_regs.sv =====
// configuration register bank for the status led pattern sequencer
module slps_cfg_regs (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [slps_pkg::CFG_IDX_W-1:0]      cfg_addr,
    input  logic [slps_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    output slps_pkg::cfg_t                      cfg
);

    slps_pkg::cfg_t cfg_reg;
    slps_pkg::cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_addr)
                slps_pkg::CFG_BLINK_PERIOD:  cfg_next.blink_period  = cfg_wdata;
                slps_pkg::CFG_FLASH_PERIOD:  cfg_next.flash_period  = cfg_wdata;
                slps_pkg::CFG_LOCK_HOLD:     cfg_next.lock_hold     = cfg_wdata;
                slps_pkg::CFG_FLASH_TOGGLES:
                    cfg_next.flash_toggles = cfg_wdata[slps_pkg::COUNT_W-1:0];
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.blink_period  <= slps_pkg::BLINK_PERIOD_RST;
            cfg_reg.flash_period  <= slps_pkg::FLASH_PERIOD_RST;
            cfg_reg.lock_hold     <= slps_pkg::LOCK_HOLD_RST;
            cfg_reg.flash_toggles <= slps_pkg::FLASH_TOGGLES_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/slps_step.sv =====
// pattern state registers and the per-beat update logic
module slps_step (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            step_en,
    input  logic                            action,
    input  logic [slps_pkg::MODE_W-1:0]     req_mode,
    input  slps_pkg::cfg_t                  cfg,
    output logic [slps_pkg::LED_W-1:0]      led,
    output logic [slps_pkg::MODE_W-1:0]     mode
);

    slps_pkg::mode_t                    mode_reg, mode_next;
    logic                               phase_reg, phase_next;
    logic [slps_pkg::COUNT_W-1:0]       toggle_cnt_reg, toggle_cnt_next;
    logic [slps_pkg::PERIOD_W-1:0]      since_toggle_reg, since_toggle_next;
    logic [slps_pkg::PERIOD_W-1:0]      since_entry_reg, since_entry_next;
    logic                               force_reg, force_next;
    logic [slps_pkg::LED_W-1:0]         led_reg, led_next;

    logic [slps_pkg::PERIOD_W-1:0]      st_inc;
    logic [slps_pkg::PERIOD_W-1:0]      se_inc;
    logic                               blink_due;
    logic                               flash_due;

    // saturating millisecond counters
    assign st_inc = (since_toggle_reg == '1) ? since_toggle_reg
                                              : since_toggle_reg + 16'd1;
    assign se_inc = (since_entry_reg == '1) ? since_entry_reg
                                             : since_entry_reg + 16'd1;
    assign blink_due = force_reg || (st_inc >= cfg.blink_period);
    assign flash_due = force_reg || (st_inc >= cfg.flash_period);

    always_comb begin
        mode_next         = mode_reg;
        phase_next        = phase_reg;
        toggle_cnt_next   = toggle_cnt_reg;
        since_toggle_next = since_toggle_reg;
        since_entry_next  = since_entry_reg;
        force_next        = force_reg;
        led_next          = led_reg;
        if (action == slps_pkg::ACT_TICK) begin
            since_toggle_next = st_inc;
            since_entry_next  = se_inc;
            unique case (mode_reg)
                slps_pkg::MODE_CONNECTING: begin
                    if (blink_due) begin
                        force_next        = 1'b0;
                        since_toggle_next = '0;
                        phase_next        = !phase_reg;
                        led_next          = !phase_reg ? slps_pkg::LED_R
                                                       : slps_pkg::LED_OFF;
                    end
                end
                slps_pkg::MODE_OFFLINE:   led_next = slps_pkg::LED_R | slps_pkg::LED_G;
                slps_pkg::MODE_CONNECTED: led_next = slps_pkg::LED_B;
                slps_pkg::MODE_LOCK: begin
                    led_next = slps_pkg::LED_R;
                    if (se_inc >= cfg.lock_hold) begin
                        mode_next = slps_pkg::MODE_CONNECTED;
                    end
                end
                slps_pkg::MODE_UNLOCK_OK, slps_pkg::MODE_UNLOCK_FAIL: begin
                    if (toggle_cnt_reg >= cfg.flash_toggles) begin
                        // flash run over: dark, back to connected
                        led_next        = slps_pkg::LED_OFF;
                        mode_next       = slps_pkg::MODE_CONNECTED;
                        toggle_cnt_next = '0;
                        force_next      = 1'b1;
                    end else if (flash_due) begin
                        force_next        = 1'b0;
                        since_toggle_next = '0;
                        phase_next        = !phase_reg;
                        if (!phase_reg) begin
                            led_next = (mode_reg == slps_pkg::MODE_UNLOCK_OK)
                                       ? slps_pkg::LED_G : slps_pkg::LED_R;
                        end else begin
                            led_next = slps_pkg::LED_OFF;
                        end
                        if (toggle_cnt_reg != '1) begin
                            toggle_cnt_next = toggle_cnt_reg + 4'd1;
                        end
                    end
                end
                default: ;
            endcase
        end else if (req_mode <= slps_pkg::MODE_UNLOCK_FAIL) begin
            mode_next        = slps_pkg::mode_t'(req_mode);
            toggle_cnt_next  = '0;
            phase_next       = 1'b0;
            since_entry_next = '0;
            force_next       = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg         <= slps_pkg::MODE_CONNECTING;
            phase_reg        <= 1'b0;
            toggle_cnt_reg   <= '0;
            since_toggle_reg <= '0;
            since_entry_reg  <= '0;
            force_reg        <= 1'b0;
            led_reg          <= slps_pkg::LED_OFF;
        end else if (step_en) begin
            mode_reg         <= mode_next;
            phase_reg        <= phase_next;
            toggle_cnt_reg   <= toggle_cnt_next;
            since_toggle_reg <= since_toggle_next;
            since_entry_reg  <= since_entry_next;
            force_reg        <= force_next;
            led_reg          <= led_next;
        end
    end

    assign led  = led_reg;
    assign mode = mode_reg;

    // blue never shares the led with red or green
    a_blue_alone: assert property (@(posedge aclk) disable iff (!aresetn)
        led_reg[2] |-> (led_reg[1:0] == 2'b00))
        else $error("blue lit together with another color");

    // a mode change leaves the led as it was
    a_set_keeps_led: assert property (@(posedge aclk) disable iff (!aresetn)
        (step_en && action == slps_pkg::ACT_SET_MODE) |=> $stable(led_reg))
        else $error("led changed on a mode change");

    // a valid mode change lands in the mode register
    a_set_mode: assert property (@(posedge aclk) disable iff (!aresetn)
        (step_en && action == slps_pkg::ACT_SET_MODE
         && req_mode <= slps_pkg::MODE_UNLOCK_FAIL)
        |=> (mode_reg == $past(req_mode)))
        else $error("mode change not taken");

    // a tick while connected shows solid blue
    a_connected_blue: assert property (@(posedge aclk) disable iff (!aresetn)
        (step_en && action == slps_pkg::ACT_TICK
         && mode_reg == slps_pkg::MODE_CONNECTED) |=> (led_reg == slps_pkg::LED_B))
        else $error("connected tick did not show blue");

endmodule

// ===== rtl/status_led_pattern_sequencer_core.sv =====
// top level of the status led pattern sequencer: input stage, state step, result stage
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+-------------------------------------------
//  s_      | in  | s_tvalid/s_tready  | tuser: action; tdata: new_mode
//  m_      | out | m_tvalid/m_tready  | tdata: red_on, green_on, blue_on, mode_now
//  cfg_    | in  | cfg_wr_en          | cfg_addr register index, cfg_wdata value
//
// one beat per cycle sustained while m_ does not stall; a beat is first held in the input register,
// then the step logic updates the pattern state, whose registers are the result
// held on m_tdata, so the result shows on m_ once the state registers are loaded
// reset (aresetn low, synchronous) empties both stages and loads the register
// defaults: blink 300, flash 200, lock hold 1000, flash toggles 6
// a stalled m_ side holds the result; the input register still takes one more
// beat, after which s_tready drops until the result is taken
module status_led_pattern_sequencer_core (
    input  logic                                aclk,
    input  logic                                aresetn,

    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [7:0]                          s_tdata,   // [2:0] new_mode
    input  logic [0:0]                          s_tuser,   // [0] action

    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [7:0]                          m_tdata,   // [0] red_on, [1] green_on,
                                                           // [2] blue_on, [5:3] mode_now

    input  logic                                cfg_wr_en,
    input  logic [slps_pkg::CFG_IDX_W-1:0]      cfg_addr,
    input  logic [slps_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    slps_pkg::cfg_t                     cfg;

    // input stage
    logic                               in_vld_reg, in_vld_next;
    logic                               in_action_reg;
    logic [slps_pkg::MODE_W-1:0]        in_mode_reg;

    // result stage
    logic                               out_vld_reg, out_vld_next;
    logic [slps_pkg::LED_W-1:0]         led;
    logic [slps_pkg::MODE_W-1:0]        mode;

    logic                               advance;
    logic                               s_beat;

    // the buffered beat moves into the state when the result slot is free
    assign advance  = in_vld_reg && (!out_vld_reg || m_tready);
    assign s_tready = !in_vld_reg || advance;
    assign s_beat   = s_tvalid && s_tready;

    assign in_vld_next  = s_tready ? s_tvalid : in_vld_reg;
    assign out_vld_next = advance ? 1'b1 : (m_tready ? 1'b0 : out_vld_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    // payload needs no reset
    always_ff @(posedge aclk) begin
        if (s_beat) begin
            in_action_reg <= s_tuser[0];
            in_mode_reg   <= s_tdata[slps_pkg::MODE_W-1:0];
        end
    end

    slps_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // pattern state doubles as the result register
    slps_step u_step (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .step_en  (advance),
        .action   (in_action_reg),
        .req_mode (in_mode_reg),
        .cfg      (cfg),
        .led      (led),
        .mode     (mode)
    );

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {2'b00, mode, led};

    // backpressure only when both stages are full and the result is stalled
    a_ready_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (in_vld_reg && out_vld_reg && !m_tready))
        else $error("input stalled without a full pipeline");

    // every step produces a result beat
    a_step_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> m_tvalid)
        else $error("step without a result beat");

endmodule

// ===== sim/tb_status_led_pattern_sequencer_core.sv =====
// self-checking testbench for the status led pattern sequencer core
module tb_status_led_pattern_sequencer_core;
    timeunit 1ns;
    timeprecision 1ps;

    import slps_pkg::*;

    // worst case is the stalled random phases
    localparam int unsigned CYCLE_LIMIT = 1_000_000;

    // one input beat: tuser carries the action, tdata the requested mode
    typedef struct packed {
        logic              act;
        logic [MODE_W-1:0] req;
    } led_cmd_t;

    // one result beat as it should appear on m_tdata
    typedef struct packed {
        logic              red_on;
        logic              green_on;
        logic              blue_on;
        logic [MODE_W-1:0] mode_now;
    } led_state_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata   = '0;   // [2:0] new_mode
    logic [0:0]            s_tuser   = '0;   // [0] action
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [7:0]            m_tdata;          // [0] red, [1] green, [2] blue, [5:3] mode_now
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    led_cmd_t   pending_beats[$];   // stimulus not yet offered to the block
    led_state_t expected_leds[$];   // predicted results, oldest first

    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned err_count      = 0;
    int unsigned cycle_count    = 0;

    // predictor copy of the register file
    logic [PERIOD_W-1:0] blink_p = BLINK_PERIOD_RST;
    logic [PERIOD_W-1:0] flash_p = FLASH_PERIOD_RST;
    logic [PERIOD_W-1:0] hold_p  = LOCK_HOLD_RST;
    logic [COUNT_W-1:0]  flash_n = FLASH_TOGGLES_RST;

    // predictor copy of the pattern state
    mode_t               cur_mode    = MODE_CONNECTING;
    logic                blink_phase = 1'b0;
    logic [COUNT_W-1:0]  tog_cnt     = '0;
    logic [PERIOD_W-1:0] since_tog   = '0;
    logic [PERIOD_W-1:0] since_ent   = '0;
    logic                force_tog   = 1'b0;
    logic [LED_W-1:0]    led         = LED_OFF;

    status_led_pattern_sequencer_core uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always #4 aclk = ~aclk;

    // a toggle is due when forced or when the period has run out
    function automatic logic take_toggle(input logic [PERIOD_W-1:0] period);
        if (force_tog || since_tog >= period) begin
            force_tog   = 1'b0;
            since_tog   = '0;
            blink_phase = ~blink_phase;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // advance the pattern state by one beat and return the led drive after it
    function automatic led_state_t step_pattern(input led_cmd_t cmd);
        led_state_t r;
        if (cmd.act == ACT_TICK) begin
            // time counters stick at all ones
            if (since_tog != '1) since_tog = since_tog + 1'b1;
            if (since_ent != '1) since_ent = since_ent + 1'b1;
            case (cur_mode)
                MODE_CONNECTING: begin
                    if (take_toggle(blink_p)) led = blink_phase ? LED_R : LED_OFF;
                end
                MODE_OFFLINE: begin
                    led = LED_R | LED_G;
                end
                MODE_CONNECTED: begin
                    led = LED_B;
                end
                MODE_LOCK: begin
                    // zero hold still shows red for this one tick
                    led = LED_R;
                    if (since_ent >= hold_p) cur_mode = MODE_CONNECTED;
                end
                MODE_UNLOCK_OK, MODE_UNLOCK_FAIL: begin
                    if (tog_cnt >= flash_n) begin
                        // flash sequence done: dark, back to connected
                        led       = LED_OFF;
                        cur_mode  = MODE_CONNECTED;
                        tog_cnt   = '0;
                        force_tog = 1'b1;
                    end else if (take_toggle(flash_p)) begin
                        if (blink_phase)
                            led = (cur_mode == MODE_UNLOCK_OK) ? LED_G : LED_R;
                        else
                            led = LED_OFF;
                        if (tog_cnt != '1) tog_cnt = tog_cnt + 1'b1;
                    end
                end
                default: ;
            endcase
        end else if (cmd.req <= MODE_UNLOCK_FAIL) begin
            // mode entry leaves the led alone until the next tick
            cur_mode    = mode_t'(cmd.req);
            tog_cnt     = '0;
            blink_phase = 1'b0;
            since_ent   = '0;
            force_tog   = 1'b1;
        end
        r.red_on   = led[0];
        r.green_on = led[1];
        r.blue_on  = led[2];
        r.mode_now = cur_mode;
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        err_count++;
        $display("%0t ns: mismatch: %s", $realtime, what);
    endtask

    // input driver: keeps a beat steady until taken, random gaps otherwise
    always @(posedge aclk) begin : drive_input
        led_cmd_t nxt;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                expected_leds.push_back(step_pattern('{act: s_tuser[0], req: s_tdata[2:0]}));
            if (!s_tvalid || s_tready) begin
                if (pending_beats.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    nxt = pending_beats.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= nxt.act;
                    s_tdata  <= {5'b0, nxt.req};
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result monitor: random back-pressure, every beat checked field by field
    always @(posedge aclk) begin : watch_result
        led_state_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_leds.size() == 0) begin
                    report_mismatch($sformatf("result beat %h with none expected", m_tdata));
                end else begin
                    want = expected_leds.pop_front();
                    if (m_tdata[0] !== want.red_on)
                        report_mismatch($sformatf("red_on got %b want %b",
                                                  m_tdata[0], want.red_on));
                    if (m_tdata[1] !== want.green_on)
                        report_mismatch($sformatf("green_on got %b want %b",
                                                  m_tdata[1], want.green_on));
                    if (m_tdata[2] !== want.blue_on)
                        report_mismatch($sformatf("blue_on got %b want %b",
                                                  m_tdata[2], want.blue_on));
                    if (m_tdata[5:3] !== want.mode_now)
                        report_mismatch($sformatf("mode_now got %0d want %0d",
                                                  m_tdata[5:3], want.mode_now));
                end
            end
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // register write, mirrored into the predictor at the edge that drives the write
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        case (idx)
            CFG_BLINK_PERIOD:  blink_p = val;
            CFG_FLASH_PERIOD:  flash_p = val;
            CFG_LOCK_HOLD:     hold_p  = val;
            CFG_FLASH_TOGGLES: flash_n = val[COUNT_W-1:0];
            default: ;
        endcase
    endtask

    task automatic write_all(input logic [15:0] blink, input logic [15:0] flash,
                             input logic [15:0] hold, input logic [15:0] toggles);
        write_reg(CFG_BLINK_PERIOD, blink);
        write_reg(CFG_FLASH_PERIOD, flash);
        write_reg(CFG_LOCK_HOLD, hold);
        write_reg(CFG_FLASH_TOGGLES, toggles);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        // queue filling happens away from the driver's edge
        @(negedge aclk);
    endtask

    // block until every queued beat went in and every result came back
    task automatic wait_drained();
        do @(negedge aclk);
        while (pending_beats.size() != 0 || s_tvalid || expected_leds.size() != 0);
        repeat (4) @(posedge aclk);
        @(negedge aclk);
    endtask

    function automatic void push_beat(input logic act, input logic [MODE_W-1:0] req);
        pending_beats.push_back('{act: act, req: req});
    endfunction

    function automatic void push_ticks(input int unsigned n);
        repeat (n) push_beat(ACT_TICK, MODE_W'($urandom_range(7)));
    endfunction

    function automatic logic [15:0] pick_period();
        case ($urandom_range(9))
            0:       return 16'd0;
            1:       return 16'hFFFF;
            2:       return 16'($urandom_range(7, 40));
            default: return 16'($urandom_range(1, 6));
        endcase
    endfunction

    function automatic logic [15:0] pick_hold();
        case ($urandom_range(9))
            0:       return 16'd0;
            1:       return 16'hFFFF;
            default: return 16'($urandom_range(1, 25));
        endcase
    endfunction

    // mode entries followed by runs of ticks, single ticks, with stray invalid requests
    function automatic void push_random(input int unsigned count);
        int unsigned made;
        int unsigned run;
        int unsigned pick;
        made = 0;
        while (made < count) begin
            pick = $urandom_range(99);
            if (pick < 6) begin
                push_beat(ACT_SET_MODE, MODE_W'($urandom_range(6, 7)));
                made++;
            end else if (pick < 30) begin
                push_beat(ACT_SET_MODE, MODE_W'($urandom_range(MODE_UNLOCK_FAIL)));
                run = $urandom_range(1, 30);
                push_ticks(run);
                made += run + 1;
            end else begin
                push_ticks(1);
                made++;
            end
        end
    endfunction

    initial begin : stimulus
        int unsigned ph;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset defaults: invalid requests, tick with every request bit set,
        // steady offline and connected colors
        push_beat(ACT_TICK, MODE_CONNECTING);
        push_beat(ACT_SET_MODE, 3'd6);
        push_beat(ACT_SET_MODE, 3'd7);
        push_beat(ACT_TICK, 3'd7);
        push_beat(ACT_SET_MODE, MODE_OFFLINE);
        push_beat(ACT_TICK, MODE_CONNECTING);
        push_beat(ACT_SET_MODE, MODE_CONNECTED);
        push_beat(ACT_TICK, MODE_CONNECTING);
        wait_drained();

        // all zero: toggle on every tick, one-tick lock, flash ends at once
        write_all(16'd0, 16'd0, 16'd0, 16'd0);
        push_beat(ACT_SET_MODE, MODE_CONNECTING);
        push_ticks(3);
        push_beat(ACT_SET_MODE, MODE_LOCK);
        push_ticks(2);
        push_beat(ACT_SET_MODE, MODE_UNLOCK_OK);
        push_ticks(2);
        push_beat(ACT_SET_MODE, MODE_UNLOCK_FAIL);
        push_ticks(2);
        wait_drained();

        // all ones: longest blink, flash and hold
        write_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        push_beat(ACT_SET_MODE, MODE_CONNECTING);
        push_ticks(40);
        push_beat(ACT_SET_MODE, MODE_LOCK);
        push_ticks(40);
        push_beat(ACT_SET_MODE, MODE_UNLOCK_OK);
        push_ticks(20);
        wait_drained();

        // random phases cycling through the idle / stall mixes
        for (ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 76; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 76; end
                default: begin send_idle_pct = 14; recv_stall_pct = 14; end
            endcase
            // upper bits of the toggle count write are don't-care garbage
            write_all(pick_period(), pick_period(), pick_hold(), 16'($urandom));
            push_random(85);
            wait_drained();
        end

        repeat (10) @(posedge aclk);
        if (expected_leds.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_leds.size()));
        if (err_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
